>>> design/iqu_pkg.sv
// Shared types and constants of the I/Q payload unpacker.
package iqu_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned PACKED_W     = 12;
    localparam int unsigned HELD_BYTES   = 3;
    localparam int unsigned HELD_W       = HELD_BYTES * BYTE_W;
    localparam int unsigned PHASE_W      = 2;
    localparam int unsigned GROUP_W      = 3;

    localparam logic [GROUP_W-1:0] GROUP_LEN_WIDE   = 3'd4;
    localparam logic [GROUP_W-1:0] GROUP_LEN_PACKED = 3'd3;

    typedef enum logic [0:0] {
        REG_MIMO_MODE       = 1'b0,
        REG_COMPRESSED_MODE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                 mimo_mode;
        logic                 compressed_mode;
    } mode_t;

    typedef struct packed {
        logic [PHASE_W-1:0]   byte_phase;
        logic [HELD_W-1:0]    held_bytes;
        logic                 next_channel;
    } unpack_state_t;

    typedef struct packed {
        logic                 valid;
        logic                 channel;
        logic [SAMPLE_W-1:0]  in_phase;
        logic [SAMPLE_W-1:0]  quadrature;
    } sample_t;

endpackage

>>> design/iqu_assemble.sv
// Byte-to-sample assembly: next group state and the completed I/Q sample.
module iqu_assemble (
    input  iqu_pkg::mode_t                  mode,
    input  iqu_pkg::unpack_state_t          state,
    input  logic [iqu_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            payload_end,
    output iqu_pkg::unpack_state_t          state_next,
    output iqu_pkg::sample_t                sample
);

    logic [iqu_pkg::GROUP_W-1:0]  group_len;
    logic [iqu_pkg::GROUP_W-1:0]  phase_plus;
    logic                         complete;
    logic [iqu_pkg::BYTE_W-1:0]   b0;
    logic [iqu_pkg::BYTE_W-1:0]   b1;
    logic [iqu_pkg::BYTE_W-1:0]   b2;
    logic [iqu_pkg::PACKED_W-1:0] i12;
    logic [iqu_pkg::PACKED_W-1:0] q12;
    logic [iqu_pkg::HELD_W-1:0]   held_upd;

    assign group_len  = mode.compressed_mode ? iqu_pkg::GROUP_LEN_PACKED
                                             : iqu_pkg::GROUP_LEN_WIDE;
    assign phase_plus = {1'b0, state.byte_phase} + 3'd1;
    assign complete   = phase_plus >= group_len;

    assign b0  = state.held_bytes[7:0];
    assign b1  = state.held_bytes[15:8];
    assign b2  = state.held_bytes[23:16];
    assign i12 = {b1[3:0], b0};
    assign q12 = {data_byte, b1[7:4]};

    always_comb begin
        held_upd = state.held_bytes;
        unique case (state.byte_phase)
            2'd0: held_upd[7:0]   = state.held_bytes[7:0]   | data_byte;
            2'd1: held_upd[15:8]  = state.held_bytes[15:8]  | data_byte;
            2'd2: held_upd[23:16] = state.held_bytes[23:16] | data_byte;
            default: held_upd     = state.held_bytes;
        endcase
    end

    always_comb begin
        sample.valid   = complete;
        sample.channel = mode.mimo_mode & state.next_channel;
        if (mode.compressed_mode) begin
            sample.in_phase   = {{(iqu_pkg::SAMPLE_W-iqu_pkg::PACKED_W){i12[11]}}, i12};
            sample.quadrature = {{(iqu_pkg::SAMPLE_W-iqu_pkg::PACKED_W){q12[11]}}, q12};
        end else begin
            sample.in_phase   = {b1, b0};
            sample.quadrature = {data_byte, b2};
        end

        if (complete) begin
            state_next.byte_phase   = '0;
            state_next.held_bytes   = '0;
            state_next.next_channel = mode.mimo_mode & ~state.next_channel;
        end else begin
            state_next.byte_phase   = phase_plus[iqu_pkg::PHASE_W-1:0];
            state_next.held_bytes   = held_upd;
            state_next.next_channel = state.next_channel;
        end

        if (payload_end) begin
            state_next = '0;
        end
    end

endmodule

>>> design/iq_payload_unpacker.sv
// Top level of the I/Q payload unpacker: byte input stage, assembly state, sample output stage.
//
// Accepts one payload byte per cycle and emits one I/Q sample per completed group
// (three bytes in 12-bit packed mode, four bytes in 16-bit mode). A byte passes a
// byte register and then the sample register, and m_valid rises once the group's last
// byte has moved into the sample register; the group state advances as a byte moves
// into the sample stage. Throughput is one byte every cycle, limited only by m_ready.
// Mode registers are written through cfg_wr_en/cfg_addr/cfg_wdata; the user must
// write them only while no transaction is in flight, which the block does not enforce;
// the last byte of a payload clears the group and returns the channel to 0.
module iq_payload_unpacker (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [0:0]                          cfg_addr,
    input  logic [0:0]                          cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [iqu_pkg::BYTE_W-1:0]          s_data_byte,
    input  logic                                s_payload_end,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_channel,
    output logic signed [iqu_pkg::SAMPLE_W-1:0] m_in_phase,
    output logic signed [iqu_pkg::SAMPLE_W-1:0] m_quadrature
);

    iqu_pkg::mode_t                 mode_reg, mode_next;
    iqu_pkg::unpack_state_t         state_reg, state_next, asm_state;
    iqu_pkg::sample_t               asm_sample;

    logic                           in_valid_reg, in_valid_next;
    logic [iqu_pkg::BYTE_W-1:0]     in_byte_reg;
    logic                           in_end_reg;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_channel_reg;
    logic [iqu_pkg::SAMPLE_W-1:0]   out_i_reg;
    logic [iqu_pkg::SAMPLE_W-1:0]   out_q_reg;

    logic                           out_free;
    logic                           advance;
    logic                           s_take;

    iqu_assemble u_assemble (
        .mode        (mode_reg),
        .state       (state_reg),
        .data_byte   (in_byte_reg),
        .payload_end (in_end_reg),
        .state_next  (asm_state),
        .sample      (asm_sample)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign s_take   = s_valid && s_ready;

    always_comb begin
        mode_next = mode_reg;
        if (cfg_wr_en) begin
            unique case (iqu_pkg::cfg_reg_t'(cfg_addr))
                iqu_pkg::REG_MIMO_MODE:       mode_next.mimo_mode       = cfg_wdata[0];
                iqu_pkg::REG_COMPRESSED_MODE: mode_next.compressed_mode = cfg_wdata[0];
                default:                      mode_next                 = mode_reg;
            endcase
        end

        state_next     = advance ? asm_state : state_reg;
        in_valid_next  = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = out_free ? (advance && asm_sample.valid) : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg.mimo_mode       <= 1'b0;
            mode_reg.compressed_mode <= 1'b1;
            state_reg                <= '0;
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            state_reg     <= state_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_payload_end;
        end
        if (advance && asm_sample.valid) begin
            out_channel_reg <= asm_sample.channel;
            out_i_reg       <= asm_sample.in_phase;
            out_q_reg       <= asm_sample.quadrature;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_channel    = out_channel_reg;
    assign m_in_phase   = out_i_reg;
    assign m_quadrature = out_q_reg;

`ifndef ASSERT_OFF
    a_end_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_end_reg |=> state_reg.byte_phase == '0 && !state_reg.next_channel)
        else $error("payload end did not clear group state");

    a_empty_group_no_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.byte_phase == '0 |-> state_reg.held_bytes == '0)
        else $error("held bytes present with empty group");

    a_packed_sign_ext: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && asm_sample.valid && mode_reg.compressed_mode |=>
        m_valid && (m_in_phase[15:11] == 5'h00 || m_in_phase[15:11] == 5'h1f) &&
        (m_quadrature[15:11] == 5'h00 || m_quadrature[15:11] == 5'h1f))
        else $error("packed sample not sign extended");
`endif

endmodule
